/* hdl/axis_and_lateral_unit_vectors_core_assert.svh */
// Assertion macros for the axis and lateral unit vector core.
// Used by the top level; no other dependencies.
`ifndef AXIS_AND_LATERAL_UNIT_VECTORS_CORE_ASSERT_SVH
`define AXIS_AND_LATERAL_UNIT_VECTORS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// implication in the same cycle, disabled during reset
`define ALUV_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// implication in the next cycle, disabled during reset
`define ALUV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ALUV_ASSERT(lbl, clk, rstn, ante, cons, msg)
`define ALUV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hdl/aluv_pkg.sv */
// Package of the axis and lateral unit vector core: widths, state types, helpers.
// Used by every module and interface of the block; depends on nothing.
package aluv_pkg;
    localparam int CW       = 32;             // coordinate width, Q16.16
    localparam int F        = 14;             // fraction bits of the unit outputs
    localparam int OW       = F + 2;          // output component width
    localparam int DW       = CW + 1;         // difference width
    localparam int MW       = DW;             // difference magnitude width
    localparam int SQ_W     = 2 * MW;         // one square
    localparam int SUM_W    = SQ_W + 2;       // sum of up to three squares
    localparam int NORM_TOP = 61;             // top bit of the scaled largest component
    localparam int SCW      = NORM_TOP + 1;   // scaled component width
    localparam int KW       = $clog2(NORM_TOP + 1);
    localparam int SQW      = 128;            // radicand width
    localparam int RW       = SQW / 2;        // root width
    localparam int QW       = F + 1;          // quotient width
    localparam int SQ_STEPS = RW;             // sqrt cells, one root bit each
    localparam int DV_STEPS = QW;             // divide cells, one quotient bit each
    localparam int LANES    = 5;              // three axis and two side components

    typedef struct packed {
        logic [SQW-1:0] rad;
        logic [RW-1:0]  root;
        logic [RW:0]    rem;
    } t_sqrt_st;

    typedef struct packed {
        logic [RW:0]   rem;
        logic [QW-1:0] q;
    } t_div_st;

    typedef struct packed {
        logic [2:0]           axis_neg;
        logic [1:0]           side_neg;
        logic                 axis_deg;
        logic                 side_deg;
        logic [2:0][SCW-1:0]  axis_sc;
        logic [1:0][SCW-1:0]  side_sc;
    } t_band;

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             axis_deg;
        logic             side_deg;
    } t_tail;

    typedef struct packed {
        t_sqrt_st axis_sq;
        t_sqrt_st side_sq;
        t_band    band;
    } t_front;

    // position of the highest set bit
    function automatic logic [KW-1:0] msb_pos(input logic [MW-1:0] v);
        logic [KW-1:0] p;
        p = '0;
        for (int i = 0; i < MW; i++) begin
            if (v[i]) p = KW'(i);
        end
        return p;
    endfunction
endpackage

/* hdl/aluv_if.sv */
// Stream interfaces of the axis and lateral unit vector core.
// Depends on aluv_pkg.
interface aluv_in_if import aluv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] first_z;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] second_z;

    modport source(output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   input ready);
    modport sink(input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 output ready);
endinterface

interface aluv_out_if import aluv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] axis_x;
    logic signed [OW-1:0] axis_y;
    logic signed [OW-1:0] axis_z;
    logic signed [OW-1:0] side_x;
    logic signed [OW-1:0] side_y;
    logic                 axis_degenerate;
    logic                 side_degenerate;

    modport source(output valid, axis_x, axis_y, axis_z, side_x, side_y,
                   axis_degenerate, side_degenerate, input ready);
    modport sink(input valid, axis_x, axis_y, axis_z, side_x, side_y,
                 axis_degenerate, side_degenerate, output ready);
endinterface

/* hdl/aluv_front.sv */
// Front end: differences, squares, leading-one shift amounts and scaling.
// Four register stages; depends on aluv_pkg.
module aluv_front import aluv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [2:0][CW-1:0]   i_p1,
    input  logic [2:0][CW-1:0]   i_p2,
    output t_front               o_front
);
    logic [2:0][MW-1:0]    r_a_mag, n_a_mag;
    logic [2:0]            r_a_neg, n_a_neg;
    logic [1:0]            r_a_sneg, n_a_sneg;

    logic [2:0][MW-1:0]    r_b_mag;
    logic [2:0]            r_b_neg;
    logic [1:0]            r_b_sneg;
    logic [2:0][SQ_W-1:0]  r_b_sq, n_b_sq;
    logic [MW-1:0]         r_b_max3, n_b_max3, r_b_max2, n_b_max2;

    logic [2:0][MW-1:0]    r_c_mag;
    logic [2:0]            r_c_neg;
    logic [1:0]            r_c_sneg;
    logic [SUM_W-1:0]      r_c_sum3, n_c_sum3, r_c_sum2, n_c_sum2;
    logic [KW-1:0]         r_c_k3, n_c_k3, r_c_k2, n_c_k2;
    logic                  r_c_deg3, r_c_deg2;

    t_front                r_d, n_d;

    // stage A: exact differences and magnitudes
    always_comb begin
        logic signed [DW-1:0] d;
        for (int i = 0; i < 3; i++) begin
            d = $signed({i_p2[i][CW-1], i_p2[i]}) - $signed({i_p1[i][CW-1], i_p1[i]});
            n_a_neg[i] = d[DW-1];
            n_a_mag[i] = d[DW-1] ? MW'(-d) : MW'(d);
        end
        // side lane 0 is -dy, lane 1 is dx
        n_a_sneg[0] = !n_a_neg[1] && (n_a_mag[1] != '0);
        n_a_sneg[1] = n_a_neg[0];
    end

    // stage B: squares and largest magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_b_sq[i] = SQ_W'(r_a_mag[i]) * SQ_W'(r_a_mag[i]);
        end
        n_b_max2 = (r_a_mag[0] > r_a_mag[1]) ? r_a_mag[0] : r_a_mag[1];
        n_b_max3 = (n_b_max2 > r_a_mag[2]) ? n_b_max2 : r_a_mag[2];
    end

    // stage C: sums of squares and scaling shifts
    always_comb begin
        n_c_sum2 = SUM_W'(r_b_sq[0]) + SUM_W'(r_b_sq[1]);
        n_c_sum3 = n_c_sum2 + SUM_W'(r_b_sq[2]);
        n_c_k3   = KW'(NORM_TOP) - msb_pos(r_b_max3);
        n_c_k2   = KW'(NORM_TOP) - msb_pos(r_b_max2);
    end

    // stage D: scaled radicands and components
    always_comb begin
        n_d.axis_sq.rad  = SQW'(r_c_sum3) << {r_c_k3, 1'b0};
        n_d.axis_sq.root = '0;
        n_d.axis_sq.rem  = '0;
        n_d.side_sq.rad  = SQW'(r_c_sum2) << {r_c_k2, 1'b0};
        n_d.side_sq.root = '0;
        n_d.side_sq.rem  = '0;
        for (int i = 0; i < 3; i++) begin
            n_d.band.axis_sc[i] = SCW'(r_c_mag[i]) << r_c_k3;
        end
        n_d.band.side_sc[0] = SCW'(r_c_mag[1]) << r_c_k2;
        n_d.band.side_sc[1] = SCW'(r_c_mag[0]) << r_c_k2;
        n_d.band.axis_neg   = r_c_neg;
        n_d.band.side_neg   = r_c_sneg;
        n_d.band.axis_deg   = r_c_deg3;
        n_d.band.side_deg   = r_c_deg2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag  <= n_a_mag;
            r_a_neg  <= n_a_neg;
            r_a_sneg <= n_a_sneg;
            r_b_mag  <= r_a_mag;
            r_b_neg  <= r_a_neg;
            r_b_sneg <= r_a_sneg;
            r_b_sq   <= n_b_sq;
            r_b_max3 <= n_b_max3;
            r_b_max2 <= n_b_max2;
            r_c_mag  <= r_b_mag;
            r_c_neg  <= r_b_neg;
            r_c_sneg <= r_b_sneg;
            r_c_sum3 <= n_c_sum3;
            r_c_sum2 <= n_c_sum2;
            r_c_k3   <= n_c_k3;
            r_c_k2   <= n_c_k2;
            r_c_deg3 <= (r_b_max3 == '0);
            r_c_deg2 <= (r_b_max2 == '0);
            r_d      <= n_d;
        end
    end

    assign o_front = r_d;
endmodule

/* hdl/aluv_sqrt_cell.sv */
// One digit cell of the square root chain: brings down two radicand bits
// and settles one root bit. Depends on aluv_pkg.
module aluv_sqrt_cell import aluv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_sqrt_st i_st,
    output t_sqrt_st o_st
);
    logic [RW+2:0] rem_x, trial;
    logic          ge;
    t_sqrt_st      r_st, n_st;

    // trial subtract of (4*root + 1)
    always_comb begin
        rem_x     = {i_st.rem, i_st.rad[SQW-1:SQW-2]};
        trial     = {1'b0, i_st.root, 2'b01};
        ge        = (rem_x >= trial);
        n_st.rem  = ge ? (RW+1)'(rem_x - trial) : (RW+1)'(rem_x);
        n_st.root = {i_st.root[RW-2:0], ge};
        n_st.rad  = {i_st.rad[SQW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_st <= n_st;
    end

    assign o_st = r_st;
endmodule

/* hdl/aluv_div_cell.sv */
// One cell of the restoring divide chain: settles one quotient bit and hands
// the doubled remainder and the divisor on. Depends on aluv_pkg.
module aluv_div_cell import aluv_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_d,
    input  t_div_st       i_st,
    output logic [RW-1:0] o_d,
    output t_div_st       o_st
);
    logic          ge;
    logic [RW:0]   diff;
    t_div_st       r_st, n_st;
    logic [RW-1:0] r_d;

    // compare, subtract, shift
    always_comb begin
        ge       = (i_st.rem >= {1'b0, i_d});
        diff     = ge ? (i_st.rem - {1'b0, i_d}) : i_st.rem;
        n_st.rem = {diff[RW-1:0], 1'b0};
        n_st.q   = {i_st.q[QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
            r_d  <= i_d;
        end
    end

    assign o_st = r_st;
    assign o_d  = r_d;
endmodule

/* hdl/axis_and_lateral_unit_vectors_core.sv */
// Axis and lateral unit vector core: every input beat carries two 3D points
// in Q16.16, every output beat the axis unit vector (P2 - P1)/|P2 - P1| and
// the horizontal lateral unit vector (-dy, dx)/|(dx, dy)|, both in Q2.14,
// with a degenerate flag each; a degenerate vector reads as zero.
// Channels are valid/ready streams; a beat moves when both are high.
// The path from the accepting edge to o_out.valid runs through four front
// stages, 64 square root cells (one root bit each), one rounding stage,
// 15 divide cells (one quotient bit each) and the output register.
// Throughput is one beat per cycle; the whole chain moves together, so its
// rate is set by the output handshake alone.
// When the receiver stalls with a result held, the chain freezes and
// i_in.ready drops until that beat is taken.
// Reset clears the valid bits of all stages; nothing else needs clearing.
// Depends on aluv_pkg, aluv_if, aluv_front, aluv_sqrt_cell, aluv_div_cell.
`include "axis_and_lateral_unit_vectors_core_assert.svh"
module axis_and_lateral_unit_vectors_core import aluv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aluv_in_if.sink    i_in,
    aluv_out_if.source o_out
);
    localparam int NV = 4 + SQ_STEPS + 1 + DV_STEPS;

    logic              en;
    logic [NV-1:0]     r_vld;
    logic              r_out_valid;
    logic [2:0][CW-1:0] p1, p2;
    t_front            front;

    t_sqrt_st          w_ax [SQ_STEPS+1];
    t_sqrt_st          w_sd [SQ_STEPS+1];
    t_band             r_band [SQ_STEPS];

    t_div_st           w_div [DV_STEPS+1][LANES];
    logic [RW-1:0]     w_dl  [DV_STEPS+1][LANES];
    t_tail             r_tl  [DV_STEPS+1];

    logic [RW-1:0]     r_len_ax, r_len_sd;
    t_div_st           r_div0 [LANES];

    logic signed [OW-1:0] r_val [LANES];
    logic                 r_adeg, r_sdeg;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    assign p1 = {i_in.first_z, i_in.first_y, i_in.first_x};
    assign p2 = {i_in.second_z, i_in.second_y, i_in.second_x};

    // valid line through all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[NV-2:0], i_in.valid};
            r_out_valid <= r_vld[NV-1];
        end
    end

    aluv_front u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_p1    (p1),
        .i_p2    (p2),
        .o_front (front)
    );

    // square root chains, axis and side side by side
    assign w_ax[0] = front.axis_sq;
    assign w_sd[0] = front.side_sq;

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sq
        aluv_sqrt_cell u_ax (.i_clk(i_clk), .i_en(en), .i_st(w_ax[s]), .o_st(w_ax[s+1]));
        aluv_sqrt_cell u_sd (.i_clk(i_clk), .i_en(en), .i_st(w_sd[s]), .o_st(w_sd[s+1]));
    end

    // sideband shift line beside the root cells
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_band[0] <= front.band;
            for (int s = 1; s < SQ_STEPS; s++) r_band[s] <= r_band[s-1];
        end
    end

    // rounding stage: nearest root, start the divides; tail line beside the divides
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_len_ax <= w_ax[SQ_STEPS].root +
                        RW'(w_ax[SQ_STEPS].rem > {1'b0, w_ax[SQ_STEPS].root});
            r_len_sd <= w_sd[SQ_STEPS].root +
                        RW'(w_sd[SQ_STEPS].rem > {1'b0, w_sd[SQ_STEPS].root});
            for (int l = 0; l < 3; l++) begin
                r_div0[l].rem <= (RW+1)'(r_band[SQ_STEPS-1].axis_sc[l]);
                r_div0[l].q   <= '0;
            end
            for (int l = 0; l < 2; l++) begin
                r_div0[3+l].rem <= (RW+1)'(r_band[SQ_STEPS-1].side_sc[l]);
                r_div0[3+l].q   <= '0;
            end
            r_tl[0].neg      <= {r_band[SQ_STEPS-1].side_neg, r_band[SQ_STEPS-1].axis_neg};
            r_tl[0].axis_deg <= r_band[SQ_STEPS-1].axis_deg;
            r_tl[0].side_deg <= r_band[SQ_STEPS-1].side_deg;
            for (int s = 1; s <= DV_STEPS; s++) r_tl[s] <= r_tl[s-1];
        end
    end

    // divide chains, one per component
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign w_div[0][l] = r_div0[l];
        assign w_dl[0][l]  = (l < 3) ? r_len_ax : r_len_sd;
        for (genvar s = 0; s < DV_STEPS; s++) begin : g_dv
            aluv_div_cell u_dv (
                .i_clk (i_clk),
                .i_en  (en),
                .i_d   (w_dl[s][l]),
                .i_st  (w_div[s][l]),
                .o_d   (w_dl[s+1][l]),
                .o_st  (w_div[s+1][l])
            );
        end
    end

    // output register: round half up, apply sign, zero degenerate vectors
    always_ff @(posedge i_clk) begin
        logic [QW-1:0] qf;
        logic          zero;
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                qf   = w_div[DV_STEPS][l].q +
                       QW'(w_div[DV_STEPS][l].rem >= {1'b0, w_dl[DV_STEPS][l]});
                zero = (l < 3) ? r_tl[DV_STEPS].axis_deg : r_tl[DV_STEPS].side_deg;
                if (zero) r_val[l] <= '0;
                else if (r_tl[DV_STEPS].neg[l]) r_val[l] <= OW'(0) - OW'(qf);
                else r_val[l] <= OW'(qf);
            end
            r_adeg <= r_tl[DV_STEPS].axis_deg;
            r_sdeg <= r_tl[DV_STEPS].side_deg;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.axis_x          = r_val[0];
    assign o_out.axis_y          = r_val[1];
    assign o_out.axis_z          = r_val[2];
    assign o_out.side_x          = r_val[3];
    assign o_out.side_y          = r_val[4];
    assign o_out.axis_degenerate = r_adeg;
    assign o_out.side_degenerate = r_sdeg;

    // coincident points are also vertical
    `ALUV_ASSERT(a_deg_nest, i_clk, i_rst_n, r_out_valid && r_adeg, r_sdeg,
                 "axis degenerate without side degenerate")
    // degenerate side vector is zero
    `ALUV_ASSERT(a_side_zero, i_clk, i_rst_n, r_out_valid && r_sdeg,
                 (r_val[3] == '0) && (r_val[4] == '0), "degenerate side vector not zero")
    // the axis x component never exceeds one in magnitude
    `ALUV_ASSERT(a_axis_bound, i_clk, i_rst_n, r_out_valid,
                 (r_val[0] <= $signed(OW'(1 << F))) && (r_val[0] >= -$signed(OW'(1 << F))),
                 "axis x out of range")
    // a stalled result stays valid and its axis x does not change until a beat moves
    `ALUV_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_out_valid && !o_out.ready,
                      r_out_valid && $stable(r_val[0]), "stalled result changed")
endmodule
